[design/gmap_pkg.sv]
package gmap_pkg;

    // fixed-point scaling of the coefficients and of the blend factor
    localparam int COEF_SHIFT = 16;
    localparam int T_SHIFT    = 24;
    localparam int COEF_W     = 19;

    // D65 XYZ to linear sRGB matrix, Q.16 rounded to nearest
    localparam logic signed [COEF_W-1:0] MAT [3][3] = '{
        '{ 19'sd212376, -19'sd100742, -19'sd32676 },
        '{ -19'sd63498,  19'sd122932,  19'sd2720  },
        '{  19'sd3650,  -19'sd13369,   19'sd69272 }
    };

    // Rec.709 luminance weights, Q.16
    localparam logic signed [COEF_W-1:0] LUMA [3] = '{ 19'sd13933, 19'sd46871, 19'sd4732 };

    // reported mapping case
    typedef enum logic [1:0] {
        MAP_IN_GAMUT = 2'd0,
        MAP_DESAT    = 2'd1,
        MAP_BLACK    = 2'd2
    } map_case_t;

endpackage

[design/gmap_div.sv]
module gmap_div #(
    parameter int NW = 37,
    parameter int QW = 24,
    parameter int SW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [NW-1:0] den,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [QW-1:0] quot,
    output logic [SW-1:0] out_side
);

    // one quotient bit per stage, restoring division of num * 2^QW by den
    logic          v_reg [QW];
    logic [NW-1:0] r_reg [QW];
    logic [NW-1:0] d_reg [QW];
    logic [QW-1:0] q_reg [QW];
    logic [SW-1:0] s_reg [QW];

    genvar k;
    generate
        for (k = 0; k < QW; k++) begin : g_stage
            logic          v_prev;
            logic [NW-1:0] r_prev;
            logic [NW-1:0] d_prev;
            logic [QW-1:0] q_prev;
            logic [SW-1:0] s_prev;
            logic [NW:0]   r_dbl;
            logic          fit;

            if (k == 0) begin : g_first
                assign v_prev = in_valid;
                assign r_prev = num;
                assign d_prev = den;
                assign q_prev = '0;
                assign s_prev = in_side;
            end
            else begin : g_next
                assign v_prev = v_reg[k-1];
                assign r_prev = r_reg[k-1];
                assign d_prev = d_reg[k-1];
                assign q_prev = q_reg[k-1];
                assign s_prev = s_reg[k-1];
            end

            // shift in one bit and try to subtract the divisor
            assign r_dbl = {r_prev, 1'b0};
            assign fit   = (r_dbl >= {1'b0, d_prev});

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k] <= 1'b0;
                end
                else
                begin
                    v_reg[k] <= v_prev;
                end
            end

            always_ff @(posedge clk)
            begin
                r_reg[k] <= fit ? NW'(r_dbl - {1'b0, d_prev}) : r_dbl[NW-1:0];
                d_reg[k] <= d_prev;
                q_reg[k] <= {q_prev[QW-2:0], fit};
                s_reg[k] <= s_prev;
            end
        end
    endgenerate

    assign out_valid = v_reg[QW-1];
    assign quot      = q_reg[QW-1];
    assign out_side  = s_reg[QW-1];

endmodule

[design/xyz_to_srgb_gamut_map_unit.sv]
// Converts one CIE XYZ pixel per clock to linear sRGB and pulls out-of-gamut colors
// toward their luminance until the lowest channel reaches zero; a pixel whose
// luminance is not above zero gives black. A beat is taken at every clock edge where
// start is high; busy is always low, so a new pixel may be given in every cycle. Each
// result appears on the output ports for one cycle with done high, in input order;
// the receiver cannot stall it. A pixel passes the matrix and luminance stages, the
// 24-stage blend-factor divider (one quotient bit per stage), then blend multipliers.
module xyz_to_srgb_gamut_map_unit #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [DATA_WIDTH-1:0] x_in,
    input  logic signed [DATA_WIDTH-1:0] y_in,
    input  logic signed [DATA_WIDTH-1:0] z_in,
    output logic                         done,
    output logic [DATA_WIDTH-2:0]        red_out,
    output logic [DATA_WIDTH-2:0]        green_out,
    output logic [DATA_WIDTH-2:0]        blue_out,
    output logic [1:0]                   map_case
);

    localparam int CS   = gmap_pkg::COEF_SHIFT;
    localparam int TS   = gmap_pkg::T_SHIFT;
    localparam int CW   = gmap_pkg::COEF_W;
    localparam int PW   = DATA_WIDTH + CW;
    localparam int AW   = PW + 2;
    localparam int RGBW = AW - CS;
    localparam int LPW  = RGBW + CW;
    localparam int LAW  = LPW + 2;
    localparam int DFW  = RGBW + 1;
    localparam int LO   = DFW / 2;
    localparam int HI   = DFW - LO;
    localparam int MW   = DFW + TS + 1;
    localparam int MRW  = MW - TS;
    localparam int FW   = MRW + 1;
    localparam int OW   = DATA_WIDTH - 1;
    localparam int SW   = 4 * RGBW + 2;

    localparam logic signed [AW-1:0]  RND_A = AW'(1) << (CS - 1);
    localparam logic signed [LAW-1:0] RND_L = LAW'(1) << (CS - 1);
    localparam logic signed [MW-1:0]  RND_T = MW'(1) << (TS - 1);
    localparam logic signed [FW-1:0]  TOP   = (FW'(1) << OW) - FW'(1);

    logic signed [DATA_WIDTH-1:0] xyz [3];

    assign busy   = 1'b0;
    assign xyz[0] = x_in;
    assign xyz[1] = y_in;
    assign xyz[2] = z_in;

    // stage 1: matrix products
    logic                 v1_reg;
    logic signed [PW-1:0] p1_reg [3][3];

    // stage 2: rounded linear rgb
    logic                   v2_reg;
    logic signed [RGBW-1:0] rgb2_reg [3];
    logic signed [RGBW-1:0] rgb2_next [3];

    // stage 3: luminance products and smallest channel
    logic                   v3_reg;
    logic signed [LPW-1:0]  lp3_reg [3];
    logic signed [RGBW-1:0] rgb3_reg [3];
    logic signed [RGBW-1:0] m3_reg;
    logic signed [RGBW-1:0] m3_next;

    // stage 4: rounded luminance
    logic                   v4_reg;
    logic signed [RGBW-1:0] lum4_reg;
    logic signed [RGBW-1:0] lum4_next;
    logic signed [RGBW-1:0] rgb4_reg [3];
    logic signed [RGBW-1:0] m4_reg;

    // stage 5: case decision and divider operands
    logic                   v5_reg;
    gmap_pkg::map_case_t    code5_reg;
    gmap_pkg::map_case_t    code5_next;
    logic [RGBW-1:0]        num5_reg;
    logic [RGBW-1:0]        den5_reg;
    logic signed [RGBW-1:0] lum5_reg;
    logic signed [RGBW-1:0] rgb5_reg [3];

    always_comb
    begin
        logic signed [AW-1:0]  acc;
        logic signed [LAW-1:0] lacc;
        for (int i = 0; i < 3; i++)
        begin
            acc = AW'(p1_reg[i][0]) + AW'(p1_reg[i][1]) + AW'(p1_reg[i][2]) + RND_A;
            rgb2_next[i] = acc[AW-1:CS];
        end
        m3_next = rgb2_reg[0];
        if (rgb2_reg[1] < m3_next)
        begin
            m3_next = rgb2_reg[1];
        end
        if (rgb2_reg[2] < m3_next)
        begin
            m3_next = rgb2_reg[2];
        end
        lacc = LAW'(lp3_reg[0]) + LAW'(lp3_reg[1]) + LAW'(lp3_reg[2]) + RND_L;
        lum4_next = lacc[CS+RGBW-1:CS];
        if (lum4_reg <= 0)
        begin
            code5_next = gmap_pkg::MAP_BLACK;
        end
        else if (m4_reg >= 0)
        begin
            code5_next = gmap_pkg::MAP_IN_GAMUT;
        end
        else
        begin
            code5_next = gmap_pkg::MAP_DESAT;
        end
    end

    // front stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // front stage data
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                p1_reg[i][j] <= PW'(xyz[j]) * PW'(gmap_pkg::MAT[i][j]);
            end
            rgb2_reg[i] <= rgb2_next[i];
            lp3_reg[i]  <= LPW'(rgb2_reg[i]) * LPW'(gmap_pkg::LUMA[i]);
            rgb3_reg[i] <= rgb2_reg[i];
            rgb4_reg[i] <= rgb3_reg[i];
            rgb5_reg[i] <= rgb4_reg[i];
        end
        m3_reg    <= m3_next;
        lum4_reg  <= lum4_next;
        m4_reg    <= m3_reg;
        code5_reg <= code5_next;
        num5_reg  <= RGBW'(lum4_reg);
        den5_reg  <= RGBW'(lum4_reg - m4_reg);
        lum5_reg  <= lum4_reg;
    end

    // blend factor t = lum * 2^24 / (lum - min)
    logic              dv;
    logic [TS-1:0]     t_q;
    logic [SW-1:0]     side_in;
    logic [SW-1:0]     side_out;

    assign side_in = {rgb5_reg[0], rgb5_reg[1], rgb5_reg[2], lum5_reg, code5_reg};

    gmap_div #(
        .NW (RGBW),
        .QW (TS),
        .SW (SW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v5_reg),
        .num       (num5_reg),
        .den       (den5_reg),
        .in_side   (side_in),
        .out_valid (dv),
        .quot      (t_q),
        .out_side  (side_out)
    );

    // unpack divider sideband
    logic signed [RGBW-1:0] rgbd [3];
    logic signed [RGBW-1:0] lumd;
    logic [1:0]             coded;

    assign rgbd[0] = side_out[SW-1 -: RGBW];
    assign rgbd[1] = side_out[SW-1-RGBW -: RGBW];
    assign rgbd[2] = side_out[SW-1-2*RGBW -: RGBW];
    assign lumd    = side_out[RGBW+1:2];
    assign coded   = side_out[1:0];

    // back stages: channel minus luminance, split products, sum, output
    logic                   v6_reg;
    logic signed [DFW-1:0]  df6_reg [3];
    logic [TS-1:0]          t6_reg;
    logic signed [RGBW-1:0] rgb6_reg [3];
    logic signed [RGBW-1:0] lum6_reg;
    logic [1:0]             code6_reg;

    logic                   v7_reg;
    logic [TS+LO-1:0]       plo7_reg [3];
    logic signed [TS+HI:0]  phi7_reg [3];
    logic signed [RGBW-1:0] rgb7_reg [3];
    logic signed [RGBW-1:0] lum7_reg;
    logic [1:0]             code7_reg;

    logic                   v8_reg;
    logic signed [MRW-1:0]  mr8_reg [3];
    logic signed [MRW-1:0]  mr8_next [3];
    logic signed [RGBW-1:0] rgb8_reg [3];
    logic signed [RGBW-1:0] lum8_reg;
    logic [1:0]             code8_reg;

    logic                   done_reg;
    logic [OW-1:0]          ch_reg [3];
    logic [OW-1:0]          ch_next [3];
    logic [1:0]             case_reg;

    always_comb
    begin
        logic signed [MW-1:0] prod;
        logic signed [FW-1:0] val;
        for (int i = 0; i < 3; i++)
        begin
            prod = (MW'(phi7_reg[i]) <<< LO) + MW'($signed({1'b0, plo7_reg[i]})) + RND_T;
            mr8_next[i] = prod[MW-1:TS];
            case (code8_reg)
                gmap_pkg::MAP_DESAT:    val = FW'(lum8_reg) + FW'(mr8_reg[i]);
                gmap_pkg::MAP_IN_GAMUT: val = FW'(rgb8_reg[i]);
                default:                val = '0;
            endcase
            if (val < 0)
            begin
                ch_next[i] = '0;
            end
            else if (val > TOP)
            begin
                ch_next[i] = TOP[OW-1:0];
            end
            else
            begin
                ch_next[i] = val[OW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg   <= 1'b0;
            v7_reg   <= 1'b0;
            v8_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v6_reg   <= dv;
            v7_reg   <= v6_reg;
            v8_reg   <= v7_reg;
            done_reg <= v8_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            df6_reg[i]  <= DFW'(rgbd[i]) - DFW'(lumd);
            rgb6_reg[i] <= rgbd[i];
            plo7_reg[i] <= (TS+LO)'(t6_reg) * (TS+LO)'(df6_reg[i][LO-1:0]);
            phi7_reg[i] <= (TS+HI+1)'($signed({1'b0, t6_reg}))
                           * (TS+HI+1)'($signed(df6_reg[i][DFW-1:LO]));
            rgb7_reg[i] <= rgb6_reg[i];
            mr8_reg[i]  <= mr8_next[i];
            rgb8_reg[i] <= rgb7_reg[i];
            ch_reg[i]   <= ch_next[i];
        end
        t6_reg    <= t_q;
        lum6_reg  <= lumd;
        code6_reg <= coded;
        lum7_reg  <= lum6_reg;
        code7_reg <= code6_reg;
        lum8_reg  <= lum7_reg;
        code8_reg <= code7_reg;
        case_reg  <= code8_reg;
    end

    assign done      = done_reg;
    assign red_out   = ch_reg[0];
    assign green_out = ch_reg[1];
    assign blue_out  = ch_reg[2];
    assign map_case  = case_reg;

`ifndef SYNTH
    // black case gives all channels zero
    a_black_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && map_case == gmap_pkg::MAP_BLACK |->
        red_out == '0 && green_out == '0 && blue_out == '0)
        else $error("black pixel with nonzero channel");

    // divisor exceeds dividend so t stays below one
    a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
        v5_reg && code5_reg == gmap_pkg::MAP_DESAT |-> den5_reg > num5_reg)
        else $error("blend factor divisor not above luminance");

    // every beat into the divider comes out once it has passed all the divider stages
    a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
        v5_reg |-> ##TS dv)
        else $error("divider valid out of step");
`endif

endmodule
